// ===== hw/rtl/eidr_pkg.sv =====
// Shared types, constants and tables for the dead reckoning block.
package eidr_pkg;

    // Default parameter values.
    localparam int ANGLE_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 32;

    // Reset value of the step length register.
    localparam logic [15:0] STEP_LENGTH_RESET = 16'd4392;

    // Width of the serial multiplier's digit operand.
    localparam int MUL_BW = 32;

    // CORDIC datapath.
    localparam int CORDIC_ITERS = 30;
    localparam int ITER_W       = 5;
    localparam int CXW          = 40;
    localparam int CZW          = 34;
    localparam logic signed [CXW-1:0] CORDIC_K     = 40'sd652032874;
    localparam logic signed [CZW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic signed [CZW-1:0] HALF_TURN    = 34'sh0_8000_0000;

    // Arctangent of 2^-i in 2^-32 turn.
    localparam logic [29:0] ATAN_TAB [CORDIC_ITERS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
        30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_INITIAL_X       = 2'd0,
        REG_INITIAL_Y       = 2'd1,
        REG_INITIAL_HEADING = 2'd2,
        REG_STEP_LENGTH     = 2'd3
    } cfg_reg_t;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic signed [31:0] initial_x;
        logic signed [31:0] initial_y;
        logic signed [15:0] initial_heading;
        logic        [15:0] step_length;
    } cfg_t;

    // One control tick.
    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] right_count;
        logic signed [15:0] left_count;
        logic               right_fresh;
        logic               left_fresh;
    } tick_t;

    // CORDIC operands and results; vec selects vectoring mode.
    typedef struct packed {
        logic                  vec;
        logic signed [CXW-1:0] x;
        logic signed [CXW-1:0] y;
        logic signed [CZW-1:0] z;
    } cordic_req_t;

endpackage

// ===== hw/rtl/eidr_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
module eidr_mul
    import eidr_pkg::*;
#(
    parameter int AW = 34,
    parameter int BW = MUL_BW
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic                    done,
    output logic signed [AW+BW-1:0] prod
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW);

    logic signed [PW-1:0] mcand_reg;
    logic signed [PW-1:0] prod_reg;
    logic        [BW-1:0] mult_reg;
    logic        [CW-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 last;
    logic signed [PW-1:0] addend;

    // The top multiplier bit carries negative weight.
    always_comb
    begin
        last = (cnt_reg == CW'(BW - 1));
        if (mult_reg[0])
        begin
            addend = last ? -mcand_reg : mcand_reg;
        end
        else
        begin
            addend = '0;
        end
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= PW'(a);
            mult_reg  <= b;
            prod_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg  <= prod_reg + addend;
            mcand_reg <= mcand_reg <<< 1;
            mult_reg  <= mult_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== hw/rtl/eidr_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
module eidr_cordic
    import eidr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cordic_req_t req,
    output logic        done,
    output cordic_req_t res
);

    logic signed [CXW-1:0] x_reg;
    logic signed [CXW-1:0] y_reg;
    logic signed [CZW-1:0] z_reg;
    logic                  vec_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic signed [CXW-1:0] xs;
    logic signed [CXW-1:0] ys;
    logic signed [CZW-1:0] atan;
    logic                  cw;
    logic                  last;

    // One micro-rotation; cw turns the vector clockwise.
    always_comb
    begin
        xs   = x_reg >>> iter_reg;
        ys   = y_reg >>> iter_reg;
        atan = $signed({{(CZW - 30){1'b0}}, ATAN_TAB[iter_reg]});
        cw   = vec_reg ? (y_reg > 0) : z_reg[CZW-1];
        last = (iter_reg == ITER_W'(CORDIC_ITERS - 1));
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            z_reg   <= req.z;
            vec_reg <= req.vec;
        end
        else if (busy_reg)
        begin
            if (cw)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan;
            end
        end
    end

    assign done    = done_reg;
    assign res.vec = vec_reg;
    assign res.x   = x_reg;
    assign res.y   = y_reg;
    assign res.z   = z_reg;

endmodule

// ===== hw/rtl/eidr_core.sv =====
// Sequencer and pose state: drives the shared multiplier and CORDIC per tick.
module eidr_core
    import eidr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tick_t                      tick,
    input  cfg_t                       cfg,
    output logic                       idle,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic signed [POS_BITS-1:0] global_x,
    output logic signed [POS_BITS-1:0] global_y
);

    localparam int MA = (POS_BITS > 34) ? POS_BITS : 34;
    localparam int PW = MA + MUL_BW;
    localparam int SW = PW + 1;
    localparam int AB = ANGLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_QXY, S_QZW, S_QYY, S_QZZ, S_CHECK, S_ATAN, S_SCREL, S_DIST,
        S_MDX, S_MDY, S_SCHEAD, S_RXC, S_RYS, S_RXS, S_RYC, S_DONE
    } state_t;

    state_t                      state_reg;
    logic                        issued_reg;
    tick_t                       tick_reg;
    logic signed [35:0]          t_reg;
    logic signed [33:0]          num_reg;
    logic signed [33:0]          den_reg;
    logic        [AB-1:0]        yaw_reg;
    logic        [AB-1:0]        ref_reg;
    logic        [AB-1:0]        rel_reg;
    logic        [2:0]           cnt_reg;
    logic                        neg_reg;
    logic signed [31:0]          c_reg;
    logic signed [31:0]          s_reg;
    logic signed [33:0]          dist_reg;
    logic signed [POS_BITS-1:0]  local_x_reg;
    logic signed [POS_BITS-1:0]  local_y_reg;
    logic signed [POS_BITS-1:0]  global_x_reg;
    logic signed [POS_BITS-1:0]  global_y_reg;
    logic signed [SW-1:0]        gacc_reg;

    logic                        mul_op;
    logic                        mul_start;
    logic                        mul_done;
    logic signed [MA-1:0]        mul_a;
    logic signed [MUL_BW-1:0]    mul_b;
    logic signed [PW-1:0]        prod;
    logic                        cord_op;
    logic                        cord_start;
    logic                        cord_done;
    cordic_req_t                 cord_req;
    cordic_req_t                 cord_res;
    logic                        fold_neg;
    logic signed [CZW-1:0]       angle;
    logic signed [35:0]          pair2;
    logic signed [SW-1:0]        dmove;
    logic signed [SW-1:0]        rterm;
    logic signed [CZW-1:0]       yaw_z;
    logic        [AB-1:0]        yaw_new;
    logic signed [31:0]          c_new;
    logic signed [31:0]          s_new;
    logic        [2:0]           cnt_new;
    logic signed [16:0]          count_sum;

    // Clamp to the signed position range.
    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = (SW'(1) <<< (POS_BITS - 1)) - SW'(1);
        lo = ~hi;
        if (v > hi)
        begin
            return hi[POS_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[POS_BITS-1:0];
        end
        return v[POS_BITS-1:0];
    endfunction

    eidr_mul #(.AW(MA), .BW(MUL_BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    eidr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .req   (cord_req),
        .done  (cord_done),
        .res   (cord_res)
    );

    // Multiplier operand selection per step.
    always_comb
    begin
        count_sum = 17'(tick_reg.left_count) + 17'(tick_reg.right_count);
        mul_op = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_QXY:
            begin
                mul_a = MA'(tick_reg.quat_x);
                mul_b = MUL_BW'(tick_reg.quat_y);
            end
            S_QZW:
            begin
                mul_a = MA'(tick_reg.quat_z);
                mul_b = MUL_BW'(tick_reg.quat_w);
            end
            S_QYY:
            begin
                mul_a = MA'(tick_reg.quat_y);
                mul_b = MUL_BW'(tick_reg.quat_y);
            end
            S_QZZ:
            begin
                mul_a = MA'(tick_reg.quat_z);
                mul_b = MUL_BW'(tick_reg.quat_z);
            end
            S_DIST:
            begin
                // A stale count on either wheel gives no travel.
                if (tick_reg.right_fresh && tick_reg.left_fresh)
                begin
                    mul_a = MA'(count_sum);
                end
                mul_b = $signed({{(MUL_BW - 16){1'b0}}, cfg.step_length});
            end
            S_MDX:
            begin
                mul_a = MA'(dist_reg);
                mul_b = c_reg;
            end
            S_MDY:
            begin
                mul_a = MA'(dist_reg);
                mul_b = s_reg;
            end
            S_RXC:
            begin
                mul_a = MA'(local_x_reg);
                mul_b = c_reg;
            end
            S_RYS:
            begin
                mul_a = MA'(local_y_reg);
                mul_b = s_reg;
            end
            S_RXS:
            begin
                mul_a = MA'(local_x_reg);
                mul_b = s_reg;
            end
            S_RYC:
            begin
                mul_a = MA'(local_y_reg);
                mul_b = c_reg;
            end
            default:
            begin
                mul_op = 1'b0;
            end
        endcase
        mul_start = mul_op && !issued_reg;
    end

    // CORDIC request: quadrant pre-rotation for the yaw, half-turn fold for sin/cos.
    always_comb
    begin
        cord_op  = 1'b1;
        fold_neg = 1'b0;
        cord_req = '0;
        if (state_reg == S_SCREL)
        begin
            angle = $signed({2'b00, rel_reg, {(32 - AB){1'b0}}});
            angle = CZW'($signed(angle[31:0]));
        end
        else
        begin
            angle = CZW'($signed({cfg.initial_heading, 16'h0000}));
        end
        unique case (state_reg)
            S_ATAN:
            begin
                cord_req.vec = 1'b1;
                if (den_reg < 0)
                begin
                    if (num_reg >= 0)
                    begin
                        cord_req.x = CXW'(num_reg);
                        cord_req.y = -CXW'(den_reg);
                        cord_req.z = QUARTER_TURN;
                    end
                    else
                    begin
                        cord_req.x = -CXW'(num_reg);
                        cord_req.y = CXW'(den_reg);
                        cord_req.z = -QUARTER_TURN;
                    end
                end
                else
                begin
                    cord_req.x = CXW'(den_reg);
                    cord_req.y = CXW'(num_reg);
                end
            end
            S_SCREL, S_SCHEAD:
            begin
                cord_req.x = CORDIC_K;
                if (angle > QUARTER_TURN)
                begin
                    cord_req.z = angle - HALF_TURN;
                    fold_neg   = 1'b1;
                end
                else if (angle < -QUARTER_TURN)
                begin
                    cord_req.z = angle + HALF_TURN;
                    fold_neg   = 1'b1;
                end
                else
                begin
                    cord_req.z = angle;
                end
            end
            default:
            begin
                cord_op = 1'b0;
            end
        endcase
        cord_start = cord_op && !issued_reg;
    end

    // Results of the shared units.
    always_comb
    begin
        pair2   = (t_reg + 36'(prod)) <<< 1;
        dmove   = (SW'(prod) + (SW'(1) <<< 38)) >>> 39;
        rterm   = (SW'(prod) + (SW'(1) <<< 29)) >>> 30;
        yaw_z   = cord_res.z + (CZW'(1) <<< (31 - AB));
        yaw_new = yaw_z[31 -: AB];
        c_new   = neg_reg ? -32'(cord_res.x) : 32'(cord_res.x);
        s_new   = neg_reg ? -32'(cord_res.y) : 32'(cord_res.y);
        cnt_new = (cnt_reg <= 3'd3) ? cnt_reg + 3'd1 : cnt_reg;
    end

    // Sequencer and pose state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            issued_reg   <= 1'b0;
            cnt_reg      <= '0;
            ref_reg      <= '0;
            rel_reg      <= '0;
            local_x_reg  <= '0;
            local_y_reg  <= '0;
            global_x_reg <= '0;
            global_y_reg <= '0;
        end
        else
        begin
            if (mul_start || cord_start)
            begin
                issued_reg <= 1'b1;
            end
            if (mul_done || cord_done)
            begin
                issued_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_QXY;
                    end
                end
                S_QXY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_QZW;
                    end
                end
                S_QZW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_QYY;
                    end
                end
                S_QYY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_QZZ;
                    end
                end
                S_QZZ:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    // A zero yaw leaves the pose untouched.
                    if (num_reg == 0 && !den_reg[33])
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_ATAN;
                    end
                end
                S_ATAN:
                begin
                    if (cord_done)
                    begin
                        cnt_reg <= cnt_new;
                        if (cnt_reg == 3'd0)
                        begin
                            ref_reg <= yaw_new;
                        end
                        state_reg <= S_SCREL;
                    end
                end
                S_SCREL:
                begin
                    if (cord_done)
                    begin
                        rel_reg   <= yaw_reg - ref_reg;
                        state_reg <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MDX;
                    end
                end
                S_MDX:
                begin
                    if (mul_done)
                    begin
                        local_x_reg <= sat_pos(SW'(local_x_reg) + dmove);
                        state_reg   <= S_MDY;
                    end
                end
                S_MDY:
                begin
                    if (mul_done)
                    begin
                        local_y_reg <= sat_pos(SW'(local_y_reg) + dmove);
                        state_reg   <= S_SCHEAD;
                    end
                end
                S_SCHEAD:
                begin
                    if (cord_done)
                    begin
                        state_reg <= S_RXC;
                    end
                end
                S_RXC:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_RYS;
                    end
                end
                S_RYS:
                begin
                    if (mul_done)
                    begin
                        global_x_reg <= sat_pos(gacc_reg - rterm);
                        state_reg    <= S_RXS;
                    end
                end
                S_RXS:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_RYC;
                    end
                end
                S_RYC:
                begin
                    if (mul_done)
                    begin
                        global_y_reg <= sat_pos(gacc_reg + rterm);
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers of one tick.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            tick_reg <= tick;
        end
        if (cord_start)
        begin
            neg_reg <= fold_neg;
        end
        if (mul_done)
        begin
            unique case (state_reg)
                S_QXY, S_QYY:
                begin
                    t_reg <= 36'(prod);
                end
                S_QZW:
                begin
                    num_reg <= 34'(pair2);
                end
                S_QZZ:
                begin
                    den_reg <= 34'sh1000_0000 - 34'(pair2);
                end
                S_DIST:
                begin
                    dist_reg <= 34'(prod);
                end
                S_RXC:
                begin
                    gacc_reg <= SW'(cfg.initial_x) + rterm;
                end
                S_RXS:
                begin
                    gacc_reg <= SW'(cfg.initial_y) + rterm;
                end
                default:
                begin
                end
            endcase
        end
        if (cord_done)
        begin
            if (state_reg == S_ATAN)
            begin
                yaw_reg <= yaw_new;
            end
            else
            begin
                c_reg <= c_new;
                s_reg <= s_new;
            end
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign global_x  = global_x_reg;
    assign global_y  = global_y_reg;

endmodule

// ===== hw/rtl/encoder_imu_dead_reckoning.sv =====
// Each tick with motion takes eleven serial multiplies and three CORDIC passes, all on
// one shared multiplier and one CORDIC; a tick whose yaw is zero takes four multiplies
// and no CORDIC pass. One tick is in work at a time.
// The next tick is taken while a result waits in the output register.
// Reset (rst_n low, asynchronous) clears the pose state, the startup counter and
// the registers, with step_length at 4392.
module encoder_imu_dead_reckoning
    import eidr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int POS_BITS   = POS_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, right_count, left_count
    input  logic [95:0] s_axis_tdata,
    // right_fresh, left_fresh
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pose_x, pose_y
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t                       cfg_reg;
    tick_t                      tick;
    logic                       idle;
    logic                       res_valid;
    logic                       res_ready;
    logic signed [POS_BITS-1:0] global_x;
    logic signed [POS_BITS-1:0] global_y;
    logic                       m_valid_reg;
    logic [63:0]                m_data_reg;

    // Unpack the input request.
    always_comb
    begin
        tick.quat_x      = s_axis_tdata[15:0];
        tick.quat_y      = s_axis_tdata[31:16];
        tick.quat_z      = s_axis_tdata[47:32];
        tick.quat_w      = s_axis_tdata[63:48];
        tick.right_count = s_axis_tdata[79:64];
        tick.left_count  = s_axis_tdata[95:80];
        tick.right_fresh = s_axis_tuser[0];
        tick.left_fresh  = s_axis_tuser[1];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_x       <= '0;
            cfg_reg.initial_y       <= '0;
            cfg_reg.initial_heading <= '0;
            cfg_reg.step_length     <= STEP_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INITIAL_X:       cfg_reg.initial_x       <= cfg_data;
                REG_INITIAL_Y:       cfg_reg.initial_y       <= cfg_data;
                REG_INITIAL_HEADING: cfg_reg.initial_heading <= cfg_data[15:0];
                REG_STEP_LENGTH:     cfg_reg.step_length     <= cfg_data[15:0];
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    eidr_core #(.ANGLE_BITS(ANGLE_BITS), .POS_BITS(POS_BITS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid),
        .tick      (tick),
        .cfg       (cfg_reg),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .global_x  (global_x),
        .global_y  (global_y)
    );

    assign s_axis_tready = idle;
    assign res_ready     = !m_valid_reg || m_axis_tready;

    // Output register decouples the result from the next tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= {32'(global_y), 32'(global_x)};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/eidr_checker.sv =====
// Port-level checks of the dead reckoning block, bound to the top level.
module eidr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // A tick in work blocks new requests.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while a tick is in work");

    // A new result appears only as a tick finishes.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a finished tick");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind encoder_imu_dead_reckoning eidr_checker u_eidr_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for the dead reckoning block: random and directed ticks against a bit-true predictor.
`timescale 1ns / 100ps

module testbench;
    import eidr_pkg::*;

    localparam int  IDLE_LIMIT = 20000;
    localparam int  LONG_HOLD  = 3000;
    localparam longint QT = 64'sd1073741824;
    localparam longint HT = 64'sd2147483648;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
    } pose_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    encoder_imu_dead_reckoning dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the registers and the pose state.
    logic signed [31:0] start_x, start_y;
    logic signed [15:0] start_heading;
    logic        [15:0] wheel_step;
    longint      loc_x, loc_y, glob_x, glob_y;
    logic [15:0] rel_heading, ref_heading;
    int          warmup;

    tick_t  tick_q[$];
    tick_t  cur_tick;
    pose_t  pose_q[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     s_acc = 0, m_acc = 0;
    bit     hold_req = 0;
    bit     fast = 0;
    bit     big_counts = 0;
    int     sgap = 0, rgap = 0, hold_cnt = 0;

    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul_q30(longint v, longint c);
        longint hi, lo, a, b;
        hi = v >>> 16;
        lo = v - hi * 65536;
        a = hi * c;
        b = lo * c + 64'sd536870912;
        return (a + (b >>> 16)) >>> 14;
    endfunction

    // Rotation-mode CORDIC with a half-turn fold, Q30 outputs.
    task automatic sin_cos(input longint ang, output longint c, output longint s);
        bit     neg;
        longint x, y, z, nx, ny;
        neg = 0;
        x = longint'(CORDIC_K);
        y = 0;
        if (ang > QT)
        begin
            ang -= HT;
            neg = 1;
        end
        else if (ang < -QT)
        begin
            ang += HT;
            neg = 1;
        end
        z = ang;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    // Vectoring-mode CORDIC, quarter-turn pre-rotation for a negative x.
    function automatic longint atan2_turn(longint y, longint x);
        longint z, t, nx, ny;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QT;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QT;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Advance the pose by one tick and return the global pose.
    task automatic advance_pose(input tick_t t, output pose_t p);
        longint qx, qy, qz, qw, num, den, z, travel, c, s, hc, hs, a;
        logic [15:0] yaw;
        qx = longint'(t.quat_x);
        qy = longint'(t.quat_y);
        qz = longint'(t.quat_z);
        qw = longint'(t.quat_w);
        num = 2 * (qx * qy + qz * qw);
        den = 64'sd268435456 - 2 * (qy * qy + qz * qz);
        if (!(num == 0 && den >= 0))
        begin
            z = atan2_turn(num, den) + 64'sd32768;
            yaw = 16'(z >>> 16);
            if (warmup <= 3)
                warmup++;
            if (warmup == 1)
                ref_heading = yaw;
            travel = 0;
            if (t.right_fresh && t.left_fresh)
                travel = longint'(wheel_step)
                         * (longint'(t.left_count) + longint'(t.right_count));
            a = longint'({rel_heading, 16'h0000});
            if (a >= HT)
                a -= 2 * HT;
            sin_cos(a, c, s);
            loc_x = sat_pos(loc_x + ((travel * c + 64'sd274877906944) >>> 39));
            loc_y = sat_pos(loc_y + ((travel * s + 64'sd274877906944) >>> 39));
            rel_heading = yaw - ref_heading;
            sin_cos(longint'(start_heading) * 65536, hc, hs);
            glob_x = sat_pos(longint'(start_x) + mul_q30(loc_x, hc) - mul_q30(loc_y, hs));
            glob_y = sat_pos(longint'(start_y) + mul_q30(loc_x, hs) + mul_q30(loc_y, hc));
        end
        p.x = glob_x[31:0];
        p.y = glob_y[31:0];
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, $signed(got), $signed(want));
        mismatches++;
    endtask

    // Input and output acceptance; expected poses are predicted at the request edge.
    always @(posedge clk)
    begin
        pose_t p;
        if (s_axis_tvalid && s_axis_tready)
        begin
            advance_pose(cur_tick, p);
            pose_q.push_back(p);
            s_acc = 1;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            m_acc = 1;
            if (pose_q.size() == 0)
                report("unexpected pose", m_axis_tdata[31:0], 32'd0);
            else
            begin
                p = pose_q.pop_front();
                if (m_axis_tdata[31:0] !== p.x)
                    report("pose_x", m_axis_tdata[31:0], p.x);
                if (m_axis_tdata[63:32] !== p.y)
                    report("pose_y", m_axis_tdata[63:32], p.y);
            end
        end
    end

    // Watchdog on cycles without any handshake on the input, output or configuration port.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Tick driver.
    always @(negedge clk)
    begin
        logic nv;
        tick_t t;
        if (s_acc)
        begin
            s_acc = 0;
            sgap = fast ? 0 : $urandom_range(0, 13);
            nv = 1'b0;
        end
        else
            nv = s_axis_tvalid;
        if (!nv && rst_n)
        begin
            if (sgap > 0)
                sgap--;
            else if (tick_q.size() > 0)
            begin
                t = tick_q.pop_front();
                cur_tick = t;
                s_axis_tdata <= {t.left_count, t.right_count, t.quat_w, t.quat_z,
                                 t.quat_y, t.quat_x};
                s_axis_tuser <= {t.left_fresh, t.right_fresh};
                nv = 1'b1;
            end
        end
        s_axis_tvalid <= nv;
    end

    // Pose receiver with random stalls and an occasional long hold-off.
    always @(negedge clk)
    begin
        logic nr;
        if (hold_req)
        begin
            hold_cnt = LONG_HOLD;
            hold_req = 0;
        end
        if (m_acc)
        begin
            m_acc = 0;
            rgap = fast ? 0 : $urandom_range(0, 13);
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            nr = 1'b0;
        end
        else if (rgap > 0)
        begin
            rgap--;
            nr = 1'b0;
        end
        else
            nr = 1'b1;
        m_axis_tready <= nr;
    end

    function automatic logic [15:0] rand_count();
        if (big_counts)
            return 16'($urandom_range(30000, 32767));
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 400) - 200);
    endfunction

    function automatic logic [15:0] rand_quat();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int    kind;
        kind = $urandom_range(0, 9);
        t.quat_x = rand_quat();
        t.quat_y = rand_quat();
        t.quat_z = rand_quat();
        t.quat_w = rand_quat();
        if (kind == 0)
        begin
            // Raw 16-bit patterns outside the Q1.14 range.
            t.quat_x = 16'($urandom);
            t.quat_y = 16'($urandom);
            t.quat_z = 16'($urandom);
            t.quat_w = 16'($urandom);
        end
        else if (kind == 1)
        begin
            // Zero yaw: no x or z component and a small y.
            t.quat_x = 16'd0;
            t.quat_z = 16'd0;
            t.quat_y = 16'($urandom_range(0, 23170) - 11585);
        end
        if (big_counts)
        begin
            // Half-turn yaw, the same as the reference, so every step adds along one axis.
            t.quat_x = 16'd0;
            t.quat_y = 16'd0;
            t.quat_z = 16'd16384;
            t.quat_w = 16'd0;
        end
        t.right_count = rand_count();
        t.left_count  = big_counts ? t.right_count : rand_count();
        t.right_fresh = big_counts || ($urandom_range(0, 4) != 0);
        t.left_fresh  = big_counts || ($urandom_range(0, 4) != 0);
        return t;
    endfunction

    function automatic tick_t make_tick(int qx, int qy, int qz, int qw,
                                        int rc, int lc, bit rf, bit lf);
        tick_t t;
        t.quat_x = 16'(qx);
        t.quat_y = 16'(qy);
        t.quat_z = 16'(qz);
        t.quat_w = 16'(qw);
        t.right_count = 16'(rc);
        t.left_count  = 16'(lc);
        t.right_fresh = rf;
        t.left_fresh  = lf;
        return t;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_INITIAL_X:       start_x = value;
            REG_INITIAL_Y:       start_y = value;
            REG_INITIAL_HEADING: start_heading = value[15:0];
            REG_STEP_LENGTH:     wheel_step = value[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every tick is sent and every pose has come back.
    task automatic drain();
        while (tick_q.size() > 0 || s_axis_tvalid || pose_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] h, input logic [15:0] st);
        write_reg(REG_INITIAL_X, x);
        write_reg(REG_INITIAL_Y, y);
        // Upper bits of the 16-bit registers are ignored.
        write_reg(REG_INITIAL_HEADING, {16'($urandom), h});
        write_reg(REG_STEP_LENGTH, {16'($urandom), st});
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            tick_q.push_back(rand_tick());
    endtask

    initial
    begin
        start_x = 0;
        start_y = 0;
        start_heading = 0;
        wheel_step = STEP_LENGTH_RESET;
        loc_x = 0;
        loc_y = 0;
        glob_x = 0;
        glob_y = 0;
        rel_heading = 0;
        ref_heading = 0;
        warmup = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed ticks at reset settings: zero yaw first, so the pose reads zero.
        tick_q.push_back(make_tick(0, 0, 0, 16384, 100, 100, 1, 1));
        tick_q.push_back(make_tick(0, 0, 0, 0, 5, 5, 1, 1));
        tick_q.push_back(make_tick(0, 0, 16384, 0, 50, 50, 1, 1));
        tick_q.push_back(make_tick(0, 0, -16384, 0, 50, 50, 1, 1));
        tick_q.push_back(make_tick(0, 0, 11585, 11585, 32767, 32767, 1, 1));
        tick_q.push_back(make_tick(16384, 16384, 16384, 16384, -32768, -32768, 1, 1));
        tick_q.push_back(make_tick(-16384, 16384, -16384, 16384, 32767, -32768, 1, 1));
        tick_q.push_back(make_tick(-32768, 32767, -32768, 32767, 1000, 1000, 1, 0));
        tick_q.push_back(make_tick(32767, -32768, 32767, -32768, 1000, 1000, 0, 1));
        tick_q.push_back(make_tick(16384, 0, 0, 16384, 1000, 1000, 0, 0));
        tick_q.push_back(make_tick(0, -11585, 0, 100, 1000, 1000, 1, 1));
        tick_q.push_back(make_tick(1, 0, 0, -1, -200, 300, 1, 1));
        tick_q.push_back(make_tick(-16384, -16384, 0, 0, 0, 0, 1, 1));
        tick_q.push_back(make_tick(0, 16384, 0, 0, -1, -1, 1, 1));
        tick_q.push_back(make_tick(0, -1, 1, 0, 32767, 0, 1, 1));
        queue_random(30);
        // Long receiver hold-off while ticks keep coming.
        @(posedge clk);
        hold_req = 1;
        drain();

        // Extreme settings, both ways.
        set_regs(32'h7fffffff, 32'h80000000, 16'h7fff, 16'hffff);
        queue_random(40);
        drain();
        set_regs(32'h80000000, 32'h7fffffff, 16'h8000, 16'h0000);
        fast = 1;
        queue_random(40);
        drain();
        fast = 0;

        // Random settings.
        set_regs($urandom, $urandom, 16'($urandom), 16'($urandom));
        queue_random(40);
        drain();

        // Long steps that drive the local accumulators into saturation.
        set_regs(32'd0, 32'd0, 16'($urandom), 16'hffff);
        big_counts = 1;
        queue_random(300);
        @(posedge clk);
        hold_req = 1;
        drain();
        big_counts = 0;
        set_regs($urandom, $urandom, 16'($urandom), 16'($urandom));
        queue_random(35);
        drain();

        repeat (600) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
